// File: rtl/core/pud_pkg.sv
// Shared types, constants and helpers of the periodic unwrap displacement block.
package pud_pkg;

  localparam int unsigned COORD_W     = 40;  // Q20.20 coordinate
  localparam int unsigned LEN_W       = 39;  // unsigned box length
  localparam int unsigned GROUP_W     = 32;
  localparam int unsigned WORD_W      = 30;  // packed image word
  localparam int unsigned DLEN_W      = 41;  // length output
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 40;
  localparam int unsigned IMAGE_FIELD_BITS_DEF = 10;

  localparam int unsigned MAG_W       = COORD_W;      // |d| fits 2^39
  localparam int unsigned HALF_W      = MAG_W / 2;
  localparam int unsigned ROOT_W      = 40;           // sum of squares < 2^80
  localparam int unsigned RAD_W       = 2 * ROOT_W;

  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned BACK_STAGES = 8;
  // accept edge to strobe: queue write, back stages, one root bit per stage
  localparam int unsigned LATENCY     = 1 + BACK_STAGES + ROOT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRICLINIC = 3'd0,
    CFG_GROUP     = 3'd1,
    CFG_BOX_X     = 3'd2,
    CFG_BOX_Y     = 3'd3,
    CFG_BOX_Z     = 3'd4,
    CFG_TILT_YZ   = 3'd5,
    CFG_TILT_XZ   = 3'd6,
    CFG_TILT_XY   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] orig_x;
    logic signed [COORD_W-1:0] orig_y;
    logic signed [COORD_W-1:0] orig_z;
    logic        [WORD_W-1:0]  image_word;
    logic        [GROUP_W-1:0] member_bits;
  } pud_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] disp_x;
    logic signed [COORD_W-1:0] disp_y;
    logic signed [COORD_W-1:0] disp_z;
    logic        [DLEN_W-1:0]  disp_length;
  } pud_result_t;

  // classified item as held in the queue
  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] orig_x;
    logic signed [COORD_W-1:0] orig_y;
    logic signed [COORD_W-1:0] orig_z;
    logic        [WORD_W-1:0]  image_word;
    logic                      in_group;
  } pud_entry_t;

  typedef struct packed {
    logic                      triclinic_enable;
    logic        [GROUP_W-1:0] group_bits;
    logic        [LEN_W-1:0]   box_len_x;
    logic        [LEN_W-1:0]   box_len_y;
    logic        [LEN_W-1:0]   box_len_z;
    logic signed [COORD_W-1:0] tilt_yz;
    logic signed [COORD_W-1:0] tilt_xz;
    logic signed [COORD_W-1:0] tilt_xy;
  } pud_cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] disp_x;
    logic signed [COORD_W-1:0] disp_y;
    logic signed [COORD_W-1:0] disp_z;
  } pud_disp_t;

  // signed width of an image count; z takes every bit above 2*fb
  function automatic int unsigned cnt_width(input int unsigned fb);
    int unsigned zw;
    zw = (WORD_W > 2 * fb) ? (WORD_W - 2 * fb) : 0;
    return ((zw > fb) ? zw : fb) + 1;
  endfunction

endpackage

// File: rtl/core/pud_front.sv
// Front end: accepts items, tests group membership, queues them for the back end.
module pud_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  pud_pkg::pud_item_t   item_i,
  input  logic [pud_pkg::GROUP_W-1:0] group_bits_i,
  input  logic                 pop_i,
  output logic                 head_valid_o,
  output pud_pkg::pud_entry_t  head_o
);
  import pud_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  pud_entry_t         q_mem [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               full, push, pop;
  pud_entry_t         entry_d;

  assign full = (count_q == CNT_W'(QDEPTH));
  assign push = start_i && !full;
  assign pop  = pop_i && (count_q != '0);

  always_comb begin
    entry_d.pos_x      = item_i.pos_x;
    entry_d.pos_y      = item_i.pos_y;
    entry_d.pos_z      = item_i.pos_z;
    entry_d.orig_x     = item_i.orig_x;
    entry_d.orig_y     = item_i.orig_y;
    entry_d.orig_z     = item_i.orig_z;
    entry_d.image_word = item_i.image_word;
    entry_d.in_group   = |(item_i.member_bits & group_bits_i);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= entry_d;
    end
  end

  assign head_o       = q_mem[rd_ptr_q];
  assign head_valid_o = (count_q != '0);
  assign busy_o       = full;

endmodule

// File: rtl/core/pud_back.sv
// Back end: image decode, unwrap products, sums with saturation, squared length.
module pud_back #(
  parameter int unsigned IMAGE_FIELD_BITS = pud_pkg::IMAGE_FIELD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  pud_pkg::pud_entry_t  head_i,
  input  pud_pkg::pud_cfg_t    cfg_i,
  output logic                 take_o,
  output logic                 rad_valid_o,
  output logic [pud_pkg::RAD_W-1:0] rad_o,
  output pud_pkg::pud_disp_t   disp_o
);
  import pud_pkg::*;

  localparam int unsigned FB     = IMAGE_FIELD_BITS;
  localparam int unsigned CNT_W  = cnt_width(FB);
  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned PROD_W = CNT_W + COORD_W;
  localparam int unsigned SUM_W  = PROD_W + 3;
  localparam int unsigned SQ_W   = 2 * HALF_W;

  localparam logic signed [CNT_W-1:0] OFFS = CNT_W'(2 ** (FB - 1));
  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN =
    {{(SUM_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

  function automatic logic signed [COORD_W-1:0] sat40(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end
    return c[COORD_W-1:0];
  endfunction

  // back end never stalls: it drains the queue whenever an entry is there
  assign take_o = head_valid_i;

  logic v_q [BACK_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BACK_STAGES; i++) begin
        v_q[i] <= 1'b0;
      end
    end else begin
      v_q[0] <= head_valid_i;
      for (int i = 1; i < BACK_STAGES; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  // stage 0: split the image word, position differences
  logic [FB-1:0]             fx, fy;
  logic [WORD_W-1:0]         fz;
  logic signed [CNT_W-1:0]   cx0_q, cy0_q, cz0_q;
  logic signed [DIFF_W-1:0]  dfx0_q, dfy0_q, dfz0_q;
  logic                      g0_q;

  assign fx = FB'(head_i.image_word);
  assign fy = FB'(head_i.image_word >> FB);
  assign fz = head_i.image_word >> (2 * FB);

  always_ff @(posedge clk_i) begin
    cx0_q  <= $signed(CNT_W'(fx)) - OFFS;
    cy0_q  <= $signed(CNT_W'(fy)) - OFFS;
    cz0_q  <= $signed(CNT_W'(fz)) - OFFS;
    dfx0_q <= DIFF_W'(head_i.pos_x) - DIFF_W'(head_i.orig_x);
    dfy0_q <= DIFF_W'(head_i.pos_y) - DIFF_W'(head_i.orig_y);
    dfz0_q <= DIFF_W'(head_i.pos_z) - DIFF_W'(head_i.orig_z);
    g0_q   <= head_i.in_group;
  end

  // stage 1: count times box length and tilt
  logic signed [PROD_W-1:0] pxx1_q, pyy1_q, pzz1_q, pxy1_q, pxz1_q, pyz1_q;
  logic signed [DIFF_W-1:0] dfx1_q, dfy1_q, dfz1_q;
  logic                     g1_q;

  always_ff @(posedge clk_i) begin
    pxx1_q <= cx0_q * $signed({1'b0, cfg_i.box_len_x});
    pyy1_q <= cy0_q * $signed({1'b0, cfg_i.box_len_y});
    pzz1_q <= cz0_q * $signed({1'b0, cfg_i.box_len_z});
    if (cfg_i.triclinic_enable) begin
      pxy1_q <= cy0_q * cfg_i.tilt_xy;
      pxz1_q <= cz0_q * cfg_i.tilt_xz;
      pyz1_q <= cz0_q * cfg_i.tilt_yz;
    end else begin
      pxy1_q <= '0;
      pxz1_q <= '0;
      pyz1_q <= '0;
    end
    dfx1_q <= dfx0_q;
    dfy1_q <= dfy0_q;
    dfz1_q <= dfz0_q;
    g1_q   <= g0_q;
  end

  // stage 2: partial sums
  logic signed [SUM_W-1:0] sxa2_q, sxb2_q, sya2_q, syb2_q, sz2_q;
  logic                    g2_q;

  always_ff @(posedge clk_i) begin
    sxa2_q <= SUM_W'(dfx1_q) + SUM_W'(pxx1_q);
    sxb2_q <= SUM_W'(pxy1_q) + SUM_W'(pxz1_q);
    sya2_q <= SUM_W'(dfy1_q) + SUM_W'(pyy1_q);
    syb2_q <= SUM_W'(pyz1_q);
    sz2_q  <= SUM_W'(dfz1_q) + SUM_W'(pzz1_q);
    g2_q   <= g1_q;
  end

  // stage 3: final sum, saturate, group gate
  logic signed [COORD_W-1:0] d3_q [3];

  always_ff @(posedge clk_i) begin
    if (g2_q) begin
      d3_q[0] <= sat40(sxa2_q + sxb2_q);
      d3_q[1] <= sat40(sya2_q + syb2_q);
      d3_q[2] <= sat40(sz2_q);
    end else begin
      d3_q[0] <= '0;
      d3_q[1] <= '0;
      d3_q[2] <= '0;
    end
  end

  // stages 4..7: magnitude, split squares, recombine, sum of squares
  logic        [MAG_W-1:0]   mag4_q [3];
  logic signed [COORD_W-1:0] d4_q [3], d5_q [3], d6_q [3], d7_q [3];
  logic        [SQ_W-1:0]    hh5_q [3], hl5_q [3], ll5_q [3];
  logic        [RAD_W-1:0]   sq6_q [3];
  logic        [RAD_W-1:0]   rad7_q;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      mag4_q[a] <= d3_q[a][COORD_W-1] ? (~d3_q[a] + MAG_W'(1)) : d3_q[a];
      d4_q[a]   <= d3_q[a];

      hh5_q[a]  <= mag4_q[a][MAG_W-1:HALF_W] * mag4_q[a][MAG_W-1:HALF_W];
      hl5_q[a]  <= mag4_q[a][MAG_W-1:HALF_W] * mag4_q[a][HALF_W-1:0];
      ll5_q[a]  <= mag4_q[a][HALF_W-1:0] * mag4_q[a][HALF_W-1:0];
      d5_q[a]   <= d4_q[a];

      sq6_q[a]  <= (RAD_W'(hh5_q[a]) << (2 * HALF_W))
                 + (RAD_W'(hl5_q[a]) << (HALF_W + 1))
                 + RAD_W'(ll5_q[a]);
      d6_q[a]   <= d5_q[a];

      d7_q[a]   <= d6_q[a];
    end
    rad7_q <= sq6_q[0] + sq6_q[1] + sq6_q[2];
  end

  assign rad_valid_o   = v_q[BACK_STAGES-1];
  assign rad_o         = rad7_q;
  assign disp_o.disp_x = d7_q[0];
  assign disp_o.disp_y = d7_q[1];
  assign disp_o.disp_z = d7_q[2];

endmodule

// File: rtl/core/pud_isqrt.sv
// Pipelined floor square root, one root bit per stage, displacement carried along.
module pud_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [pud_pkg::RAD_W-1:0]  rad_i,
  input  pud_pkg::pud_disp_t         disp_i,
  output logic                       valid_o,
  output logic [pud_pkg::ROOT_W-1:0] root_o,
  output pud_pkg::pud_disp_t         disp_o
);
  import pud_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 2;

  logic              vld_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  pud_disp_t         disp_q [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W-1];
  logic [RAD_W-1:0]  rad_q  [ROOT_W-1];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic              vld_in;
    logic [REM_W-1:0]  rem_in, rem_sh, trial;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    pud_disp_t         disp_in;
    logic              ge;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign disp_in = disp_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign disp_in = disp_q[s-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {rem_in[ROOT_W-1:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      root_q[s] <= {root_in[ROOT_W-2:0], ge};
      disp_q[s] <= disp_in;
    end

    if (s < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[s] <= ge ? (rem_sh - trial) : rem_sh;
        rad_q[s] <= rad_in << 2;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign disp_o  = disp_q[ROOT_W-1];

endmodule

// File: rtl/core/periodic_unwrap_displacement.sv
// Top level of the periodic unwrap displacement block: config registers and pipeline.
//
//  channel  | ports                                   | transfer
//  ---------+-----------------------------------------+-------------------------------
//  item in  | start, busy, item_i                     | edge with start high, busy low
//  result   | done_o, result_o                        | edge ending the done_o cycle
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i        | edge with cfg_we_i high
//
// One transaction per clock in, one result per clock out. From the accept edge
// to the edge that takes the result (LATENCY in the package), an item passes
// one queue slot, eight arithmetic stages, and one stage per root bit of the
// 40-bit square root. The back end drains the queue every cycle, so
// busy stays low in operation. Reset clears the config registers (group_bits
// to 1, all else to 0), the queue pointers and all stage valid bits. The
// receiver cannot stall; there is no clearing pass.
module periodic_unwrap_displacement #(
  parameter int unsigned IMAGE_FIELD_BITS = pud_pkg::IMAGE_FIELD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item transactions
  input  logic                           start,
  output logic                           busy,
  input  pud_pkg::pud_item_t             item_i,
  // result transactions
  output logic                           done_o,
  output pud_pkg::pud_result_t           result_o,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [pud_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pud_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import pud_pkg::*;

  pud_cfg_t          cfg_q;
  logic              pop;
  logic              head_valid;
  pud_entry_t        head;
  logic              rad_valid;
  logic [RAD_W-1:0]  rad;
  pud_disp_t         disp_back, disp_out;
  logic [ROOT_W-1:0] root;

  // config register file; to be written only while the pipe is empty, not enforced by the block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.triclinic_enable <= 1'b0;
      cfg_q.group_bits       <= GROUP_W'(1);
      cfg_q.box_len_x        <= '0;
      cfg_q.box_len_y        <= '0;
      cfg_q.box_len_z        <= '0;
      cfg_q.tilt_yz          <= '0;
      cfg_q.tilt_xz          <= '0;
      cfg_q.tilt_xy          <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_TRICLINIC: cfg_q.triclinic_enable <= cfg_wdata_i[0];
        CFG_GROUP:     cfg_q.group_bits       <= cfg_wdata_i[GROUP_W-1:0];
        CFG_BOX_X:     cfg_q.box_len_x        <= cfg_wdata_i[LEN_W-1:0];
        CFG_BOX_Y:     cfg_q.box_len_y        <= cfg_wdata_i[LEN_W-1:0];
        CFG_BOX_Z:     cfg_q.box_len_z        <= cfg_wdata_i[LEN_W-1:0];
        CFG_TILT_YZ:   cfg_q.tilt_yz          <= cfg_wdata_i[COORD_W-1:0];
        CFG_TILT_XZ:   cfg_q.tilt_xz          <= cfg_wdata_i[COORD_W-1:0];
        CFG_TILT_XY:   cfg_q.tilt_xy          <= cfg_wdata_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // front: accept, group test, queue
  pud_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .item_i       (item_i),
    .group_bits_i (cfg_q.group_bits),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // back: unwrap, subtract, saturate, sum of squares
  pud_back #(
    .IMAGE_FIELD_BITS (IMAGE_FIELD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .cfg_i        (cfg_q),
    .take_o       (pop),
    .rad_valid_o  (rad_valid),
    .rad_o        (rad),
    .disp_o       (disp_back)
  );

  // length: truncated root, one bit per stage
  pud_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rad_valid),
    .rad_i   (rad),
    .disp_i  (disp_back),
    .valid_o (done_o),
    .root_o  (root),
    .disp_o  (disp_out)
  );

  assign result_o.disp_x      = disp_out.disp_x;
  assign result_o.disp_y      = disp_out.disp_y;
  assign result_o.disp_z      = disp_out.disp_z;
  assign result_o.disp_length = DLEN_W'(root);

endmodule

// File: rtl/core/pud_chk.sv
// Port-level checks of the periodic unwrap displacement block, bound to the top level.
module pud_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 done_o,
  input pud_pkg::pud_result_t result_o
);
  import pud_pkg::*;

  logic [MAG_W-1:0] mag_x, mag_y, mag_z;
  logic             disp_zero;

  always_comb begin
    mag_x = result_o.disp_x[COORD_W-1] ? (~result_o.disp_x + MAG_W'(1)) : result_o.disp_x;
    mag_y = result_o.disp_y[COORD_W-1] ? (~result_o.disp_y + MAG_W'(1)) : result_o.disp_y;
    mag_z = result_o.disp_z[COORD_W-1] ? (~result_o.disp_z + MAG_W'(1)) : result_o.disp_z;
    disp_zero = (result_o.disp_x == '0) && (result_o.disp_y == '0) && (result_o.disp_z == '0);
  end

  // the back end drains every cycle, so the queue never fills
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  // every result traces back to a transaction a fixed latency earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result without matching transaction");

  // zero length exactly when the displacement vector is zero
  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((result_o.disp_length == '0) == disp_zero))
    else $error("length and displacement disagree on zero");

  // length is never shorter than any component
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((result_o.disp_length >= DLEN_W'(mag_x)) &&
                (result_o.disp_length >= DLEN_W'(mag_y)) &&
                (result_o.disp_length >= DLEN_W'(mag_z))))
    else $error("length below a component magnitude");

endmodule

bind periodic_unwrap_displacement pud_chk u_pud_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

// File: dv/periodic_unwrap_displacement_test.sv
// Self-checking testbench of periodic_unwrap_displacement: directed corners and random traffic.
module periodic_unwrap_displacement_test;
  import pud_pkg::*;

  // image field layout of the default build
  localparam int FB = IMAGE_FIELD_BITS_DEF;

  localparam logic signed [COORD_W-1:0] Q_MAX = 40'sh7f_ffff_ffff;
  localparam logic signed [COORD_W-1:0] Q_MIN = 40'sh80_0000_0000;
  localparam longint SAT_HI = 64'sd549755813887;
  localparam longint SAT_LO = -64'sd549755813888;

  // all three counts at zero, all at the low end, all at the high end
  localparam logic [WORD_W-1:0] WORD_CENTER = {10'd512, 10'd512, 10'd512};
  localparam logic [WORD_W-1:0] WORD_LOW    = '0;
  localparam logic [WORD_W-1:0] WORD_HIGH   = '1;

  // Golden model plus expected-result store. Every accepted transaction
  // pushes one prediction; every strobed result pops and compares the oldest.
  class disp_scoreboard;
    pud_cfg_t    regs;
    pud_result_t pending_disp[$];
    int unsigned errors;

    function new();
      regs            = '0;
      regs.group_bits = 1;
      errors          = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TRICLINIC: regs.triclinic_enable = data[0];
        CFG_GROUP:     regs.group_bits       = data[GROUP_W-1:0];
        CFG_BOX_X:     regs.box_len_x        = data[LEN_W-1:0];
        CFG_BOX_Y:     regs.box_len_y        = data[LEN_W-1:0];
        CFG_BOX_Z:     regs.box_len_z        = data[LEN_W-1:0];
        CFG_TILT_YZ:   regs.tilt_yz          = data;
        CFG_TILT_XZ:   regs.tilt_xz          = data;
        CFG_TILT_XY:   regs.tilt_xy          = data;
        default: ;
      endcase
    endfunction

    function longint clamp_q40(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    // unwrap with the box shape, subtract the original, saturate, then length
    function pud_result_t unwrap_displacement(pud_item_t it);
      longint            word, fmask, half, cx, cy, cz;
      longint            d[3];
      logic [COORD_W-1:0] mag;
      logic [83:0]       sum_sq, trial_sq;
      logic [DLEN_W-1:0] root, trial;
      pud_result_t       r;
      r = '0;
      if ((it.member_bits & regs.group_bits) == '0) return r;
      word  = longint'(it.image_word);
      fmask = (64'sd1 <<< FB) - 1;
      half  = 64'sd1 <<< (FB - 1);
      cx    = (word & fmask) - half;
      cy    = ((word >> FB) & fmask) - half;
      cz    = (word >> (2 * FB)) - half;   // z takes every bit above the y field
      d[0] = longint'(it.pos_x) + cx * longint'(regs.box_len_x) - longint'(it.orig_x);
      d[1] = longint'(it.pos_y) + cy * longint'(regs.box_len_y) - longint'(it.orig_y);
      d[2] = longint'(it.pos_z) + cz * longint'(regs.box_len_z) - longint'(it.orig_z);
      if (regs.triclinic_enable) begin
        d[0] += cy * longint'(regs.tilt_xy) + cz * longint'(regs.tilt_xz);
        d[1] += cz * longint'(regs.tilt_yz);
      end
      sum_sq = '0;
      foreach (d[i]) begin
        d[i]   = clamp_q40(d[i]);
        mag    = COORD_W'((d[i] < 0) ? -d[i] : d[i]);
        sum_sq = sum_sq + 84'(mag) * 84'(mag);
      end
      // truncated square root, one bit at a time from the top
      root = '0;
      for (int b = DLEN_W - 1; b >= 0; b--) begin
        trial    = root | (41'd1 << b);
        trial_sq = 84'(trial) * 84'(trial);
        if (trial_sq <= sum_sq) root = trial;
      end
      r.disp_x      = d[0][COORD_W-1:0];
      r.disp_y      = d[1][COORD_W-1:0];
      r.disp_z      = d[2][COORD_W-1:0];
      r.disp_length = root;
      return r;
    endfunction

    function void note_item(pud_item_t it);
      pending_disp.push_back(unwrap_displacement(it));
    endfunction

    function void check_result(pud_result_t got);
      pud_result_t want;
      if (pending_disp.size() == 0) begin
        $error("result with no transaction pending");
        errors++;
        return;
      end
      want = pending_disp.pop_front();
      if (got.disp_x !== want.disp_x) begin
        $error("disp_x: expected %0d, got %0d", want.disp_x, got.disp_x);
        errors++;
      end
      if (got.disp_y !== want.disp_y) begin
        $error("disp_y: expected %0d, got %0d", want.disp_y, got.disp_y);
        errors++;
      end
      if (got.disp_z !== want.disp_z) begin
        $error("disp_z: expected %0d, got %0d", want.disp_z, got.disp_z);
        errors++;
      end
      if (got.disp_length !== want.disp_length) begin
        $error("disp_length: expected %0d, got %0d", want.disp_length, got.disp_length);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_disp.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  pud_item_t             item_i;
  logic                  done_o;
  pud_result_t           result_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  disp_scoreboard sb = new();

  periodic_unwrap_displacement DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Monitor: sees pre-edge values, so inputs and outputs are sampled race free.
  // A transaction goes in on start && !busy; a result counts on its done_o cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_item(item_i);
      if (done_o) sb.check_result(result_o);
    end
  end

  // Hold one transaction on the inputs until the block takes it.
  task automatic send_item(input pud_item_t it);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
  endtask

  // n >= 1, so start never gets two updates in one step
  task automatic idle(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Sender pause until every predicted result has been checked.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  // Write all eight registers; junk in the unused upper data bits must be ignored.
  task automatic set_regs(input pud_cfg_t c);
    logic [63:0]           junk;
    logic [CFG_DATA_W-1:0] vals [8];
    cfg_reg_e              idx;
    junk               = {$urandom, $urandom};
    vals[CFG_TRICLINIC] = {junk[39:1], c.triclinic_enable};
    vals[CFG_GROUP]     = {junk[7:0], c.group_bits};
    vals[CFG_BOX_X]     = {junk[8], c.box_len_x};
    vals[CFG_BOX_Y]     = {junk[9], c.box_len_y};
    vals[CFG_BOX_Z]     = {junk[10], c.box_len_z};
    vals[CFG_TILT_YZ]   = c.tilt_yz;
    vals[CFG_TILT_XZ]   = c.tilt_xz;
    vals[CFG_TILT_XY]   = c.tilt_xy;
    idx = idx.first();
    do begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= vals[idx];
      @(posedge clk_i);
      sb.write_reg(idx, vals[idx]);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return r[LEN_W-1:0];
      default: return {12'b0, r[26:0]};   // below 128 length units
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_tilt();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return Q_MAX;
      2:       return Q_MIN;
      3:       return r[COORD_W-1:0];
      default: return COORD_W'($signed(r[24:0]));
    endcase
  endfunction

  function automatic pud_cfg_t random_cfg(input logic triclinic);
    pud_cfg_t c;
    c.triclinic_enable = triclinic;
    case ($urandom_range(0, 11))
      0:       c.group_bits = '0;          // whole phase filtered out
      1, 2:    c.group_bits = '1;
      3, 4:    c.group_bits = 32'd1 << $urandom_range(0, 31);
      default: c.group_bits = $urandom;
    endcase
    c.box_len_x = pick_len();
    c.box_len_y = pick_len();
    c.box_len_z = pick_len();
    c.tilt_yz   = pick_tilt();
    c.tilt_xz   = pick_tilt();
    c.tilt_xy   = pick_tilt();
    return c;
  endfunction

  // Mostly atoms near their origin with a few box crossings; one in ten is
  // pure noise over every bit of every field.
  function automatic pud_item_t random_item();
    pud_item_t   it;
    logic [63:0] w [6];
    foreach (w[i]) w[i] = {$urandom, $urandom};
    it.pos_x       = w[0][COORD_W-1:0];
    it.pos_y       = w[1][COORD_W-1:0];
    it.pos_z       = w[2][COORD_W-1:0];
    it.orig_x      = w[3][COORD_W-1:0];
    it.orig_y      = w[4][COORD_W-1:0];
    it.orig_z      = w[5][COORD_W-1:0];
    it.image_word  = 30'($urandom);
    it.member_bits = $urandom;
    if ($urandom_range(0, 9) != 0) begin
      it.pos_x      = COORD_W'($signed(w[0][27:0]));
      it.pos_y      = COORD_W'($signed(w[1][27:0]));
      it.pos_z      = COORD_W'($signed(w[2][27:0]));
      it.orig_x     = it.pos_x + COORD_W'($signed(w[3][23:0]));
      it.orig_y     = it.pos_y + COORD_W'($signed(w[4][23:0]));
      it.orig_z     = it.pos_z + COORD_W'($signed(w[5][23:0]));
      it.image_word = {10'($urandom_range(508, 516)), 10'($urandom_range(508, 516)),
                       10'($urandom_range(508, 516))};
      case ($urandom_range(0, 7))
        0:       it.member_bits = '0;
        1:       it.member_bits = 32'd1 << $urandom_range(0, 31);
        default: ;
      endcase
    end
    return it;
  endfunction

  // Bursts of back-to-back transactions, random gaps, now and then a full pause.
  task automatic run_random(input int unsigned count);
    int unsigned sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        if (sent < count) begin
          send_item(random_item());
          sent++;
        end
      end
      if ($urandom_range(0, 15) == 0) drain();
      else if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
    end
  endtask

  initial begin
    pud_cfg_t c;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    item_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_TRICLINIC;
    cfg_wdata_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: zero boxes, group bit 0 only.
    send_item('{'0, '0, '0, '0, '0, '0, WORD_CENTER, 32'd1});
    // x saturates high, y saturates low
    send_item('{Q_MAX, Q_MIN, '0, Q_MIN, Q_MAX, '0, WORD_HIGH, 32'd1});
    // outside the group: all zeros
    send_item('{Q_MAX, Q_MAX, Q_MAX, '0, '0, '0, WORD_LOW, 32'd2});
    drain();

    // Orthogonal, largest boxes; tilts at max must have no effect here.
    c = '{triclinic_enable: 1'b0, group_bits: '1, box_len_x: '1, box_len_y: '1,
          box_len_z: '1, tilt_yz: Q_MAX, tilt_xz: Q_MAX, tilt_xy: Q_MAX};
    set_regs(c);
    send_item('{'0, '0, '0, '0, '0, '0, WORD_LOW, 32'h8000_0000});
    send_item('{'0, '0, '0, '0, '0, '0, WORD_HIGH, '1});
    send_item('{Q_MIN, Q_MAX, 40'sd1, Q_MAX, Q_MIN, -40'sd1, WORD_CENTER, 32'h1234_5678});
    // one box up with pos just below orig: lands one short of the top, no clamp
    send_item('{-40'sd1, -40'sd1, -40'sd1, '0, '0, '0, {10'd513, 10'd513, 10'd513}, '1});
    send_item('{'0, '0, '0, '0, '0, '0, WORD_CENTER, '0});
    drain();

    // Triclinic with opposing extreme tilts and a single high group bit.
    c = '{triclinic_enable: 1'b1, group_bits: 32'h8000_0000, box_len_x: 39'd1 << 24,
          box_len_y: 39'd3 << 23, box_len_z: 39'd5 << 22,
          tilt_yz: Q_MIN, tilt_xz: Q_MAX, tilt_xy: Q_MIN};
    set_regs(c);
    send_item('{'0, '0, '0, '0, '0, '0, {10'd511, 10'd513, 10'd512}, 32'h8000_0000});
    send_item('{40'sd1000, -40'sd1000, '0, '0, '0, '0, WORD_HIGH, '1});
    send_item('{'0, '0, '0, '0, '0, '0, WORD_LOW, '1});
    send_item('{'0, '0, '0, '0, '0, '0, WORD_HIGH, 32'h7fff_ffff});
    drain();

    // Random phases alternate orthogonal and triclinic boxes.
    for (int phase = 0; phase < 6; phase++) begin
      set_regs(random_cfg(phase[0]));
      run_random(156);
      drain();
    end

    // nothing may arrive once all predictions are used up
    repeat (LATENCY + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("periodic_unwrap_displacement_test passed");
    end else begin
      $display("periodic_unwrap_displacement_test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("periodic_unwrap_displacement_test failed");
    $finish;
  end

endmodule
